/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/bstk_pkg.sv */
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared types and codes of the bounded stack.
// ----------------------------------------------------------------------------
`default_nettype none

package bstk_pkg;

	localparam int DEPTH_DEF = 16;

	typedef logic [1:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_PUSH = 2'd0;
	localparam mode_t MODE_POP  = 2'd1;
	localparam mode_t MODE_DISP = 2'd2;
	localparam mode_t MODE_PAL  = 2'd3;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;
	localparam status_t ST_EMPTY     = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_WR,
		S_DISP_RD,
		S_DISP_WR,
		S_PAL_RD,
		S_PAL_CMP,
		S_PAL_DONE
	} state_t;

	typedef enum logic [2:0] {
		OUT_PUSH_OK,
		OUT_OVF,
		OUT_UNF,
		OUT_EMPTY,
		OUT_WORD,
		OUT_PAL
	} out_sel_t;

	typedef struct packed {
		logic     push;
		logic     pop;
		logic     disp_init;
		logic     pal_init;
		logic     rd;
		logic     step_dn;
		logic     pal_step;
		logic     clear;
		logic     ld_out;
		out_sel_t out_sel;
		logic     out_last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic few;
		logic lo_zero;
		logic pal_more;
		logic slot_free;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/bstk_dp.sv */
// ----------------------------------------------------------------------------
// bstk_dp
// Stack memory, fill count, walk pointers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bstk_dp #(
	parameter int DEPTH = bstk_pkg::DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic signed [31:0]  push_value,
	input  wire bstk_pkg::cmd_t      cmd,
	output bstk_pkg::sts_t           sts,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output bstk_pkg::status_t        status,
	output logic signed [31:0]       word_out,
	output logic                     is_palindrome,
	output logic                     last
);
	import bstk_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [31:0]   mem [DEPTH];
	logic [CW-1:0] count_q;
	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] lo_q;
	logic [AW-1:0] hi_q;
	logic [AW-1:0] lo_n;
	logic [AW-1:0] hi_n;
	logic [AW-1:0] addr_a;
	logic [31:0]   rd_a_q;
	logic [31:0]   rd_b_q;
	logic          pal_ok_q;
	logic          out_valid_q;
	status_t       status_q;
	logic [31:0]   word_q;
	logic          pal_q;
	logic          last_q;
	status_t       status_d;
	logic [31:0]   word_d;
	logic          pal_d;
	logic          last_d;

	assign cnt_m1 = count_q - CW'(1);
	assign lo_n   = lo_q + AW'(1);
	assign hi_n   = hi_q - AW'(1);
	assign addr_a = cmd.pop ? cnt_m1[AW-1:0] : lo_q;

	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.empty     = (count_q == '0);
	assign sts.few       = (count_q < CW'(2));
	assign sts.lo_zero   = (lo_q == '0);
	assign sts.pal_more  = (lo_n < hi_n);
	assign sts.slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[count_q[AW-1:0]] <= push_value;
		end
		if (cmd.pop || cmd.rd) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[hi_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= cnt_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.disp_init) begin
			lo_q <= cnt_m1[AW-1:0];
		end else if (cmd.pal_init) begin
			lo_q     <= '0;
			hi_q     <= cnt_m1[AW-1:0];
			pal_ok_q <= 1'b1;
		end else if (cmd.step_dn) begin
			lo_q <= lo_q - AW'(1);
		end else if (cmd.pal_step) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
			if (rd_a_q != rd_b_q) begin
				pal_ok_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status_d = ST_OK;
		word_d   = '0;
		pal_d    = 1'b0;
		last_d   = 1'b1;
		unique case (cmd.out_sel)
			OUT_PUSH_OK: status_d = ST_OK;
			OUT_OVF:     status_d = ST_OVERFLOW;
			OUT_UNF:     status_d = ST_UNDERFLOW;
			OUT_EMPTY:   status_d = ST_EMPTY;
			OUT_WORD: begin
				word_d = rd_a_q;
				last_d = cmd.out_last;
			end
			OUT_PAL:     pal_d = pal_ok_q;
			default:     status_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			status_q <= status_d;
			word_q   <= word_d;
			pal_q    <= pal_d;
			last_q   <= last_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign word_out      = word_q;
	assign is_palindrome = pal_q;
	assign last          = last_q;

endmodule

`default_nettype wire

/* rtl/bstk_ctrl.sv */
// ----------------------------------------------------------------------------
// bstk_ctrl
// Operation sequencer: accepts an item and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module bstk_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire bstk_pkg::mode_t   mode,
	input  wire bstk_pkg::sts_t    sts,
	output bstk_pkg::cmd_t         cmd
);
	import bstk_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = !((state_q == S_IDLE) && sts.slot_free);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (mode)
						MODE_PUSH: state_d = S_IDLE;
						MODE_POP:  state_d = sts.empty ? S_IDLE : S_POP_WR;
						MODE_DISP: state_d = sts.empty ? S_IDLE : S_DISP_RD;
						default:   state_d = sts.few ? S_PAL_DONE : S_PAL_RD;
					endcase
				end
			end
			S_POP_WR:  if (sts.slot_free) state_d = S_IDLE;
			S_DISP_RD: state_d = S_DISP_WR;
			S_DISP_WR: begin
				if (sts.slot_free) begin
					state_d = sts.lo_zero ? S_IDLE : S_DISP_RD;
				end
			end
			S_PAL_RD:  state_d = S_PAL_CMP;
			S_PAL_CMP: state_d = sts.pal_more ? S_PAL_RD : S_PAL_DONE;
			S_PAL_DONE: if (sts.slot_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.out_sel = OUT_PUSH_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (mode)
						MODE_PUSH: begin
							cmd.ld_out  = 1'b1;
							cmd.push    = !sts.full;
							cmd.out_sel = sts.full ? OUT_OVF : OUT_PUSH_OK;
						end
						MODE_POP: begin
							cmd.pop     = !sts.empty;
							cmd.ld_out  = sts.empty;
							cmd.out_sel = OUT_UNF;
						end
						MODE_DISP: begin
							cmd.disp_init = !sts.empty;
							cmd.ld_out    = sts.empty;
							cmd.out_sel   = OUT_EMPTY;
						end
						default: cmd.pal_init = 1'b1;
					endcase
				end
			end
			S_POP_WR: begin
				cmd.ld_out   = sts.slot_free;
				cmd.out_sel  = OUT_WORD;
				cmd.out_last = 1'b1;
			end
			S_DISP_RD: cmd.rd = 1'b1;
			S_DISP_WR: begin
				cmd.ld_out   = sts.slot_free;
				cmd.out_sel  = OUT_WORD;
				cmd.out_last = sts.lo_zero;
				cmd.step_dn  = sts.slot_free && !sts.lo_zero;
			end
			S_PAL_RD:  cmd.rd = 1'b1;
			S_PAL_CMP: cmd.pal_step = 1'b1;
			S_PAL_DONE: begin
				cmd.ld_out  = sts.slot_free;
				cmd.clear   = sts.slot_free;
				cmd.out_sel = OUT_PAL;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/bounded_stack_with_palindrome_check.sv */
// ----------------------------------------------------------------------------
// bounded_stack_with_palindrome_check
// Fixed-depth LIFO of signed words with push, pop, display and palindrome.
// ----------------------------------------------------------------------------
// One item is handled at a time; the stack memory has one write port and two
// registered read ports; a word that is returned is read into a read register
// and then loaded into the output register. Push and every error or empty
// result are loaded from the idle state; pop reads the top word, then loads
// it; display does so for each entry from the top down; palindrome reads and
// compares pairs from both ends, then loads the flag. Result stalls hold loads.
`default_nettype none
`include "assert_macros.svh"

module bounded_stack_with_palindrome_check #(
	parameter int DEPTH = bstk_pkg::DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire bstk_pkg::mode_t    mode,
	input  wire logic signed [31:0] push_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output bstk_pkg::status_t       status,
	output logic signed [31:0]      word_out,
	output logic                    is_palindrome,
	output logic                    last
);
	import bstk_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bstk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	bstk_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.push_value    (push_value),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.word_out      (word_out),
		.is_palindrome (is_palindrome),
		.last          (last)
	);

	`ASSERT_CLK(a_accept_slot_free, (in_valid && !in_stall) |-> (!out_valid || !out_stall), "item accepted while result blocked")
	`ASSERT_CLK(a_push_result, (in_valid && !in_stall && mode == MODE_PUSH) |=> (out_valid && last), "push gave no result")
	`ASSERT_CLK(a_error_last, (out_valid && status != ST_OK) |-> last, "error result not last")
	`ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result valid in reset")

endmodule

`default_nettype wire
